@@ hw/rtl/clx_pkg.sv @@
package clx_pkg;

  // Token classes, in output code order
  typedef enum logic [5:0] {
    TK_INT, TK_FLOAT, TK_CHAR, TK_VOID, TK_IF, TK_ELSE, TK_WHILE, TK_FOR, TK_RETURN,
    TK_IDENT, TK_INT_LIT, TK_FLOAT_LIT, TK_CHAR_LIT, TK_STR_LIT,
    TK_PLUS, TK_MINUS, TK_STAR, TK_SLASH, TK_PERCENT, TK_ASSIGN, TK_EQ, TK_NE,
    TK_LT, TK_LE, TK_GT, TK_GE, TK_AND, TK_OR, TK_NOT,
    TK_LPAREN, TK_RPAREN, TK_LBRACE, TK_RBRACE, TK_SEMI, TK_COMMA,
    TK_EOF, TK_ERROR
  } tok_kind_e;

  // Scanner modes
  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_NUM, MODE_STR, MODE_STR_ESC, MODE_CHR, MODE_CHR_ESC,
    MODE_HELD
  } mode_e;

  // Input item
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_input;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_item_t;

  // Results of one step, r0 first
  typedef struct packed {
    logic [1:0] cnt;
    out_item_t  r1;
    out_item_t  r0;
  } push_t;

  // Result queue (depth must be a power of two)
  localparam int RES_FIFO_DEPTH = 4;
  localparam int RF_PTR_W       = $clog2(RES_FIFO_DEPTH);
  localparam int RF_CNT_W       = $clog2(RES_FIFO_DEPTH + 1);

  // Keyword buffer: longest keyword is six bytes
  localparam int KW_BUF_LEN = 6;
  localparam int KW_IDX_W   = $clog2(KW_BUF_LEN);
  localparam int KW_LEN_W   = $clog2(KW_BUF_LEN + 1);
  typedef logic [KW_BUF_LEN-1:0][7:0] word_buf_t;

  // Byte codes
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_NL        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BANG      = 8'h21;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_PERCENT   = 8'h25;
  localparam logic [7:0] CH_AMP       = 8'h26;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_STAR      = 8'h2A;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_MINUS     = 8'h2D;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_0         = 8'h30;
  localparam logic [7:0] CH_9         = 8'h39;
  localparam logic [7:0] CH_SEMI      = 8'h3B;
  localparam logic [7:0] CH_LT        = 8'h3C;
  localparam logic [7:0] CH_EQ        = 8'h3D;
  localparam logic [7:0] CH_GT        = 8'h3E;
  localparam logic [7:0] CH_UC_A      = 8'h41;
  localparam logic [7:0] CH_UC_Z      = 8'h5A;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER     = 8'h5F;
  localparam logic [7:0] CH_LC_A      = 8'h61;
  localparam logic [7:0] CH_LC_Z      = 8'h7A;
  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_BAR       = 8'h7C;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[CH_LC_A:CH_LC_Z]}) || (c inside {[CH_UC_A:CH_UC_Z]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  function automatic logic is_op_start(input logic [7:0] c);
    return c inside {CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR};
  endfunction

  // One-byte token class; anything unknown is an error token
  function automatic tok_kind_e single_kind(input logic [7:0] c);
    tok_kind_e k;
    case (c)
      CH_PLUS:    k = TK_PLUS;
      CH_MINUS:   k = TK_MINUS;
      CH_STAR:    k = TK_STAR;
      CH_SLASH:   k = TK_SLASH;
      CH_PERCENT: k = TK_PERCENT;
      CH_EQ:      k = TK_ASSIGN;
      CH_LT:      k = TK_LT;
      CH_GT:      k = TK_GT;
      CH_BANG:    k = TK_NOT;
      CH_LPAREN:  k = TK_LPAREN;
      CH_RPAREN:  k = TK_RPAREN;
      CH_LBRACE:  k = TK_LBRACE;
      CH_RBRACE:  k = TK_RBRACE;
      CH_SEMI:    k = TK_SEMI;
      CH_COMMA:   k = TK_COMMA;
      default:    k = TK_ERROR;
    endcase
    return k;
  endfunction

  // Two-byte operator match
  function automatic logic pair_ok(input logic [7:0] a, input logic [7:0] b);
    return ((b == CH_EQ) && (a inside {CH_EQ, CH_BANG, CH_LT, CH_GT})) ||
           ((a == CH_AMP) && (b == CH_AMP)) || ((a == CH_BAR) && (b == CH_BAR));
  endfunction

  function automatic tok_kind_e pair_kind(input logic [7:0] a);
    tok_kind_e k;
    case (a)
      CH_EQ:   k = TK_EQ;
      CH_BANG: k = TK_NE;
      CH_LT:   k = TK_LE;
      CH_GT:   k = TK_GE;
      CH_AMP:  k = TK_AND;
      default: k = TK_OR;
    endcase
    return k;
  endfunction

  // Keyword lookup on the first len buffered bytes
  function automatic tok_kind_e kw_lookup(input word_buf_t w, input logic [KW_LEN_W-1:0] len);
    tok_kind_e k;
    k = TK_IDENT;
    case (len)
      KW_LEN_W'(2): if ({w[0], w[1]} == "if") k = TK_IF;
      KW_LEN_W'(3): begin
        if ({w[0], w[1], w[2]} == "int") k = TK_INT;
        else if ({w[0], w[1], w[2]} == "for") k = TK_FOR;
      end
      KW_LEN_W'(4): begin
        if ({w[0], w[1], w[2], w[3]} == "char") k = TK_CHAR;
        else if ({w[0], w[1], w[2], w[3]} == "void") k = TK_VOID;
        else if ({w[0], w[1], w[2], w[3]} == "else") k = TK_ELSE;
      end
      KW_LEN_W'(5): begin
        if ({w[0], w[1], w[2], w[3], w[4]} == "float") k = TK_FLOAT;
        else if ({w[0], w[1], w[2], w[3], w[4]} == "while") k = TK_WHILE;
      end
      KW_LEN_W'(6): if ({w[0], w[1], w[2], w[3], w[4], w[5]} == "return") k = TK_RETURN;
      default: k = TK_IDENT;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/clx_step.sv @@
module clx_step #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  clx_pkg::in_item_t item_i,
  output clx_pkg::push_t    push_o
);
  import clx_pkg::*;

  localparam int PB = POSITION_BITS;
  localparam logic [PB-1:0] POS_ONE = PB'(1);

  function automatic logic [PB-1:0] sat_inc(input logic [PB-1:0] v);
    return (&v) ? v : v + POS_ONE;
  endfunction

  function automatic out_item_t mk(input tok_kind_e k, input logic [PB-1:0] ln,
                                   input logic [PB-1:0] col, input logic [PB-1:0] len);
    out_item_t r;
    r.token_kind   = k;
    r.start_line   = 16'(ln);
    r.start_column = 16'(col);
    r.token_length = 16'(len);
    r.last_of_run  = 1'b0;
    return r;
  endfunction

  mode_e           mode_q, mode_d;
  logic [7:0]      held_q, held_d;
  logic            saw_dot_q, saw_dot_d;
  logic [PB-1:0]   cur_line_q, cur_line_d, cur_col_q, cur_col_d;
  logic [PB-1:0]   tok_line_q, tok_line_d, tok_col_q, tok_col_d;
  logic [PB-1:0]   rl_q, rl_d;
  word_buf_t       wbuf_q;
  logic            wr_en;
  logic [KW_IDX_W-1:0] wr_idx;

  logic [7:0]      c;
  logic            eoi;

  // start-of-token decode for the current byte
  logic            sb_starts, sb_emit;
  mode_e           sb_mode;
  logic [PB-1:0]   sb_line, sb_col;

  // pending-token flush
  tok_kind_e       fl_kind;
  logic [PB-1:0]   fl_len;
  out_item_t       fl_r, sb_r;

  // step decisions
  logic            do_flush, take_start, x_v;
  out_item_t       x_r, r0, r1;
  logic [1:0]      n;

  assign c   = item_i.character;
  assign eoi = item_i.end_of_input;

  // Classify a byte seen between tokens
  always_comb begin
    sb_starts = 1'b0;
    sb_emit   = 1'b0;
    sb_mode   = MODE_IDLE;
    sb_line   = cur_line_q;
    sb_col    = sat_inc(cur_col_q);
    if (c == CH_NL) begin
      sb_line = sat_inc(cur_line_q);
      sb_col  = POS_ONE;
    end else if (!(c inside {CH_SPACE, CH_TAB, CH_CR})) begin
      sb_starts = 1'b1;
      if (is_alpha(c) || c == CH_UNDER) sb_mode = MODE_WORD;
      else if (is_digit(c))             sb_mode = MODE_NUM;
      else if (c == CH_DQUOTE)          sb_mode = MODE_STR;
      else if (c == CH_SQUOTE)          sb_mode = MODE_CHR;
      else if (is_op_start(c))          sb_mode = MODE_HELD;
      else                              sb_emit = 1'b1;
    end
  end

  // Token that ends when the current mode is closed
  always_comb begin
    fl_len = rl_q;
    case (mode_q)
      MODE_WORD: fl_kind = (rl_q <= PB'(KW_BUF_LEN)) ?
                           kw_lookup(wbuf_q, rl_q[KW_LEN_W-1:0]) : TK_IDENT;
      MODE_NUM:  fl_kind = saw_dot_q ? TK_FLOAT_LIT : TK_INT_LIT;
      MODE_STR, MODE_STR_ESC: fl_kind = TK_STR_LIT;
      MODE_CHR, MODE_CHR_ESC: fl_kind = TK_CHAR_LIT;
      MODE_HELD: begin
        fl_kind = single_kind(held_q);
        fl_len  = POS_ONE;
      end
      default:   fl_kind = TK_ERROR;
    endcase
  end

  assign fl_r = mk(fl_kind, tok_line_q, tok_col_q, fl_len);
  assign sb_r = mk(single_kind(c), cur_line_q, cur_col_q, POS_ONE);

  // Per-byte state update and result selection
  always_comb begin
    mode_d     = mode_q;
    held_d     = held_q;
    saw_dot_d  = saw_dot_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    rl_d       = rl_q;
    wr_en      = 1'b0;
    wr_idx     = '0;
    do_flush   = 1'b0;
    take_start = 1'b0;
    x_v        = 1'b0;
    x_r        = '0;
    r0         = '0;
    r1         = '0;
    n          = 2'd0;

    if (eoi) begin
      // flush, EOF at the current position, back to reset state
      do_flush   = (mode_q != MODE_IDLE);
      x_v        = 1'b1;
      x_r        = mk(TK_EOF, cur_line_q, cur_col_q, '0);
      mode_d     = MODE_IDLE;
      held_d     = '0;
      saw_dot_d  = 1'b0;
      cur_line_d = POS_ONE;
      cur_col_d  = POS_ONE;
      tok_line_d = POS_ONE;
      tok_col_d  = POS_ONE;
      rl_d       = '0;
    end else begin
      case (mode_q)
        MODE_WORD: begin
          if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
            if (rl_q < PB'(KW_BUF_LEN)) begin
              wr_en  = 1'b1;
              wr_idx = rl_q[KW_IDX_W-1:0];
            end
            rl_d      = sat_inc(rl_q);
            cur_col_d = sat_inc(cur_col_q);
          end else begin
            do_flush   = 1'b1;
            take_start = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit(c) || c == CH_DOT) begin
            if (c == CH_DOT) saw_dot_d = 1'b1;
            rl_d      = sat_inc(rl_q);
            cur_col_d = sat_inc(cur_col_q);
          end else begin
            do_flush   = 1'b1;
            take_start = 1'b1;
          end
        end
        MODE_STR, MODE_CHR: begin
          rl_d      = sat_inc(rl_q);
          cur_col_d = sat_inc(cur_col_q);
          if (c == CH_BACKSLASH) begin
            mode_d = (mode_q == MODE_STR) ? MODE_STR_ESC : MODE_CHR_ESC;
          end else if (c == ((mode_q == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
            x_v    = 1'b1;
            x_r    = mk((mode_q == MODE_STR) ? TK_STR_LIT : TK_CHAR_LIT,
                        tok_line_q, tok_col_q, sat_inc(rl_q));
            mode_d = MODE_IDLE;
          end
        end
        MODE_STR_ESC, MODE_CHR_ESC: begin
          // escaped byte is taken as is
          rl_d      = sat_inc(rl_q);
          cur_col_d = sat_inc(cur_col_q);
          mode_d    = (mode_q == MODE_STR_ESC) ? MODE_STR : MODE_CHR;
        end
        MODE_HELD: begin
          if (pair_ok(held_q, c)) begin
            cur_col_d = sat_inc(cur_col_q);
            x_v       = 1'b1;
            x_r       = mk(pair_kind(held_q), tok_line_q, tok_col_q, PB'(2));
            mode_d    = MODE_IDLE;
          end else begin
            do_flush   = 1'b1;
            take_start = 1'b1;
          end
        end
        default: take_start = 1'b1;
      endcase

      // begin a new token (or skip whitespace) from between-token state
      if (take_start) begin
        mode_d     = MODE_IDLE;
        cur_line_d = sb_line;
        cur_col_d  = sb_col;
        if (sb_starts) begin
          tok_line_d = cur_line_q;
          tok_col_d  = cur_col_q;
          rl_d       = POS_ONE;
          mode_d     = sb_mode;
          if (sb_mode == MODE_WORD) begin
            wr_en  = 1'b1;
            wr_idx = '0;
          end
          if (sb_mode == MODE_NUM)  saw_dot_d = 1'b0;
          if (sb_mode == MODE_HELD) held_d = c;
        end
      end
    end

    // results in order: flushed token, closing/EOF token, punctuation
    if (do_flush) begin
      r0 = fl_r;
      n  = 2'd1;
    end
    if (x_v) begin
      if (n == 2'd0) r0 = x_r;
      else           r1 = x_r;
      n = n + 2'd1;
    end
    if (take_start && sb_emit) begin
      if (n == 2'd0) r0 = sb_r;
      else           r1 = sb_r;
      n = n + 2'd1;
    end
    if (n == 2'd1) r0.last_of_run = 1'b1;
    if (n == 2'd2) r1.last_of_run = 1'b1;
  end

  assign push_o.cnt = fire_i ? n : 2'd0;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

  // Scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      held_q     <= '0;
      saw_dot_q  <= 1'b0;
      cur_line_q <= POS_ONE;
      cur_col_q  <= POS_ONE;
      tok_line_q <= POS_ONE;
      tok_col_q  <= POS_ONE;
      rl_q       <= '0;
    end else if (fire_i) begin
      mode_q     <= mode_d;
      held_q     <= held_d;
      saw_dot_q  <= saw_dot_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
      rl_q       <= rl_d;
    end
  end

  // Keyword buffer, valid only up to the current word length
  always_ff @(posedge clk_i) begin
    if (fire_i && wr_en) begin
      wbuf_q[wr_idx] <= c;
    end
  end

  a_eof_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && eoi |=> mode_q == MODE_IDLE && cur_line_q == POS_ONE && cur_col_q == POS_ONE)
    else $error("end of input did not return the scanner to its start state");

  a_last_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.cnt == 2'd2 |-> push_o.r1.last_of_run && !push_o.r0.last_of_run)
    else $error("last_of_run misplaced on a two-token step");

  a_eof_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && eoi |-> (push_o.cnt == 2'd1 && push_o.r0.token_kind == TK_EOF) ||
                      (push_o.cnt == 2'd2 && push_o.r1.token_kind == TK_EOF))
    else $error("end of input must close with exactly one EOF token");

endmodule

@@ hw/rtl/clx_res_fifo.sv @@
module clx_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clx_pkg::push_t     push_i,
  input  logic               pop_i,
  output clx_pkg::out_item_t head_o,
  output logic               not_empty_o,
  output logic               room2_o
);
  import clx_pkg::*;

  out_item_t           mem_q [RES_FIFO_DEPTH];
  logic [RF_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr1;
  logic [RF_CNT_W-1:0] count_q;

  assign wr_ptr1     = wr_ptr_q + RF_PTR_W'(1);
  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign room2_o     = (count_q <= RF_CNT_W'(RES_FIFO_DEPTH - 2));

  // Entry storage: up to two writes per cycle at consecutive slots
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) mem_q[wr_ptr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) mem_q[wr_ptr1]  <= push_i.r1;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + RF_PTR_W'(push_i.cnt);
      if (pop_i) rd_ptr_q <= rd_ptr_q + RF_PTR_W'(1);
      count_q  <= count_q + RF_CNT_W'(push_i.cnt) - RF_CNT_W'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.cnt != 2'd0 |->
      int'(count_q) + int'(push_i.cnt) <= RES_FIFO_DEPTH + int'(pop_i))
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("result queue read while empty");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != RF_CNT_W'(RES_FIFO_DEPTH) |->
      RF_PTR_W'(wr_ptr_q - rd_ptr_q) == RF_PTR_W'(count_q))
    else $error("queue pointers disagree with fill count");

endmodule

@@ hw/rtl/c_subset_lexer.sv @@
// Streaming tokenizer for a small C subset. Each input transfer carries one source byte
// (or an end-of-input mark); each output transfer carries one token: kind, start line,
// start column and length, with last_of_run set on the final token caused by a byte.
// A byte is registered, then scanned combinationally; bytes are taken one per cycle
// unless the input stalls, and each token goes to a four-entry result queue, leaving
// it one per cycle while the receiver is ready. The input stalls while fewer than two
// queue slots are free, so a byte that closes one token and starts a punctuation token,
// or end of input after a pending token, always finds room. End of input flushes
// the pending token, emits EOF and returns the scanner to its reset state. Line,
// column and length saturate at 2**POSITION_BITS-1 and are reported in 16 bits.
module c_subset_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  clx_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output clx_pkg::out_item_t out_item_o
);
  import clx_pkg::*;

  logic     in_vld_q;
  in_item_t in_q;
  logic     step_fire, room2, not_empty;
  push_t    push;

  // Input register: refills in the same cycle it is consumed
  assign step_fire  = in_vld_q && room2;
  assign in_ready_o = !in_vld_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // Scanner
  clx_step #(
    .POSITION_BITS(POSITION_BITS)
  ) u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (step_fire),
    .item_i (in_q),
    .push_o (push)
  );

  // Result queue
  clx_res_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (out_valid_o && out_ready_i),
    .head_o      (out_item_o),
    .not_empty_o (not_empty),
    .room2_o     (room2)
  );

  assign out_valid_o = not_empty;

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import clx_pkg::*;

  localparam int          RAND_ITEMS  = 1450;
  localparam int          STALL_LIMIT = 1000;
  localparam int          DRAIN_WAIT  = 20;
  localparam logic [15:0] KW_MAX      = 16'(KW_BUF_LEN);
  localparam logic [15:0] POS_SAT     = 16'hFFFF;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  c_subset_lexer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Source bytes waiting to be sent, and tokens still owed by the block
  in_item_t    src_q[$];
  out_item_t   exp_tokens[$];
  out_item_t   run_toks[$];
  int          items_left = 0;
  int          mismatches = 0;
  int unsigned src_gap = 0, snk_gap = 0, src_burst = 0, snk_burst = 0;
  int          idle_cycles = 0;

  // Scanner model state
  mode_e       scan_st = MODE_IDLE;
  logic [7:0]  held_op = '0;
  logic [7:0]  word_bytes [KW_BUF_LEN];
  logic        long_word = 1'b0;
  logic        has_dot = 1'b0;
  logic [15:0] cur_line = 16'd1, cur_col = 16'd1;
  logic [15:0] tok_line = 16'd1, tok_col = 16'd1, tok_len = 16'd0;

  function automatic logic [15:0] sat_up(input logic [15:0] v);
    return (v == POS_SAT) ? v : v + 16'd1;
  endfunction

  function automatic logic letter_byte(input logic [7:0] c);
    return (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= CH_0 && c <= CH_9;
  endfunction

  function automatic logic op_lead(input logic [7:0] c);
    return c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
           c == CH_AMP || c == CH_BAR;
  endfunction

  function automatic tok_kind_e punct_kind(input logic [7:0] c);
    case (c)
      CH_PLUS:    return TK_PLUS;
      CH_MINUS:   return TK_MINUS;
      CH_STAR:    return TK_STAR;
      CH_SLASH:   return TK_SLASH;
      CH_PERCENT: return TK_PERCENT;
      CH_EQ:      return TK_ASSIGN;
      CH_LT:      return TK_LT;
      CH_GT:      return TK_GT;
      CH_BANG:    return TK_NOT;
      CH_LPAREN:  return TK_LPAREN;
      CH_RPAREN:  return TK_RPAREN;
      CH_LBRACE:  return TK_LBRACE;
      CH_RBRACE:  return TK_RBRACE;
      CH_SEMI:    return TK_SEMI;
      CH_COMMA:   return TK_COMMA;
      default:    return TK_ERROR;
    endcase
  endfunction

  // Two-byte operator; returns 0 when the pair does not combine
  function automatic logic op_pair(input logic [7:0] a, input logic [7:0] b,
                                   output tok_kind_e k);
    k = TK_ERROR;
    if (b == CH_EQ) begin
      case (a)
        CH_EQ:   k = TK_EQ;
        CH_BANG: k = TK_NE;
        CH_LT:   k = TK_LE;
        CH_GT:   k = TK_GE;
        default: k = TK_ERROR;
      endcase
    end
    if (a == CH_AMP && b == CH_AMP) k = TK_AND;
    if (a == CH_BAR && b == CH_BAR) k = TK_OR;
    return k != TK_ERROR;
  endfunction

  // Keyword spelling, indexed in token code order
  function automatic string keyword_text(input int i);
    case (i)
      0:       return "int";
      1:       return "float";
      2:       return "char";
      3:       return "void";
      4:       return "if";
      5:       return "else";
      6:       return "while";
      7:       return "for";
      default: return "return";
    endcase
  endfunction

  function automatic tok_kind_e word_class();
    string kw;
    logic  hit;
    if (long_word || tok_len > KW_MAX) return TK_IDENT;
    for (int i = 0; i < 9; i++) begin
      kw = keyword_text(i);
      if (kw.len() == int'(tok_len)) begin
        hit = 1'b1;
        for (int j = 0; j < kw.len(); j++)
          if (word_bytes[j] != kw[j]) hit = 1'b0;
        if (hit) return tok_kind_e'(i);
      end
    end
    return TK_IDENT;
  endfunction

  task automatic push_token(input tok_kind_e k, input logic [15:0] len);
    out_item_t t;
    t.token_kind   = k;
    t.start_line   = tok_line;
    t.start_column = tok_col;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    run_toks.push_back(t);
  endtask

  task automatic word_append(input logic [7:0] c);
    if (tok_len < KW_MAX) word_bytes[tok_len[2:0]] = c;
    else long_word = 1'b1;
    tok_len = sat_up(tok_len);
  endtask

  task automatic flush_pending();
    case (scan_st)
      MODE_WORD:               push_token(word_class(), tok_len);
      MODE_NUM:                push_token(has_dot ? TK_FLOAT_LIT : TK_INT_LIT, tok_len);
      MODE_STR, MODE_STR_ESC:  push_token(TK_STR_LIT, tok_len);
      MODE_CHR, MODE_CHR_ESC:  push_token(TK_CHAR_LIT, tok_len);
      MODE_HELD:               push_token(punct_kind(held_op), 16'd1);
      default: ;
    endcase
    scan_st = MODE_IDLE;
  endtask

  // A byte seen between tokens: skip blanks or open a new token
  task automatic open_token(input logic [7:0] c);
    if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
      cur_col = sat_up(cur_col);
    end else if (c == CH_NL) begin
      cur_line = sat_up(cur_line);
      cur_col  = 16'd1;
    end else begin
      tok_line = cur_line;
      tok_col  = cur_col;
      cur_col  = sat_up(cur_col);
      tok_len  = 16'd1;
      if (letter_byte(c) || c == CH_UNDER) begin
        scan_st   = MODE_WORD;
        long_word = 1'b0;
        tok_len   = 16'd0;
        word_append(c);
      end else if (digit_byte(c)) begin
        scan_st = MODE_NUM;
        has_dot = 1'b0;
      end else if (c == CH_DQUOTE) begin
        scan_st = MODE_STR;
      end else if (c == CH_SQUOTE) begin
        scan_st = MODE_CHR;
      end else if (op_lead(c)) begin
        scan_st = MODE_HELD;
        held_op = c;
      end else begin
        push_token(punct_kind(c), 16'd1);
      end
    end
  endtask

  task automatic reset_scanner();
    scan_st   = MODE_IDLE;
    held_op   = '0;
    long_word = 1'b0;
    has_dot   = 1'b0;
    cur_line  = 16'd1;
    cur_col   = 16'd1;
    tok_line  = 16'd1;
    tok_col   = 16'd1;
    tok_len   = 16'd0;
  endtask

  // Tokens caused by one accepted byte, appended to exp_tokens
  task automatic tokenize(input in_item_t it);
    tok_kind_e  k;
    logic [7:0] c;
    out_item_t  t;
    c = it.character;
    run_toks.delete();
    if (it.end_of_input) begin
      flush_pending();
      tok_line = cur_line;
      tok_col  = cur_col;
      push_token(TK_EOF, 16'd0);
      reset_scanner();
    end else begin
      case (scan_st)
        MODE_WORD: begin
          if (letter_byte(c) || digit_byte(c) || c == CH_UNDER) begin
            word_append(c);
            cur_col = sat_up(cur_col);
          end else begin
            flush_pending();
            open_token(c);
          end
        end
        MODE_NUM: begin
          if (digit_byte(c) || c == CH_DOT) begin
            if (c == CH_DOT) has_dot = 1'b1;
            tok_len = sat_up(tok_len);
            cur_col = sat_up(cur_col);
          end else begin
            flush_pending();
            open_token(c);
          end
        end
        MODE_STR, MODE_CHR: begin
          tok_len = sat_up(tok_len);
          cur_col = sat_up(cur_col);
          if (c == CH_BACKSLASH) begin
            scan_st = (scan_st == MODE_STR) ? MODE_STR_ESC : MODE_CHR_ESC;
          end else if (c == ((scan_st == MODE_STR) ? CH_DQUOTE : CH_SQUOTE)) begin
            push_token((scan_st == MODE_STR) ? TK_STR_LIT : TK_CHAR_LIT, tok_len);
            scan_st = MODE_IDLE;
          end
        end
        MODE_STR_ESC, MODE_CHR_ESC: begin
          tok_len = sat_up(tok_len);
          cur_col = sat_up(cur_col);
          scan_st = (scan_st == MODE_STR_ESC) ? MODE_STR : MODE_CHR;
        end
        MODE_HELD: begin
          if (op_pair(held_op, c, k)) begin
            cur_col = sat_up(cur_col);
            push_token(k, 16'd2);
            scan_st = MODE_IDLE;
          end else begin
            flush_pending();
            open_token(c);
          end
        end
        default: begin
          scan_st = MODE_IDLE;
          open_token(c);
        end
      endcase
    end
    // last_of_run marks the final token of this byte
    for (int i = 0; i < run_toks.size(); i++) begin
      t = run_toks[i];
      t.last_of_run = (i == run_toks.size() - 1);
      exp_tokens.push_back(t);
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_token(input out_item_t got);
    out_item_t want;
    if (exp_tokens.size() == 0) begin
      mismatches++;
      $display("%0t: unexpected token, expected none, actual kind %0d line %0d col %0d len %0d",
               $time, got.token_kind, got.start_line, got.start_column, got.token_length);
      return;
    end
    want = exp_tokens.pop_front();
    compare_field("token_kind", 16'(want.token_kind), 16'(got.token_kind));
    compare_field("start_line", want.start_line, got.start_line);
    compare_field("start_column", want.start_column, got.start_column);
    compare_field("token_length", want.token_length, got.token_length);
    compare_field("last_of_run", 16'(want.last_of_run), 16'(got.last_of_run));
  endtask

  // Wait before the next item; occasional runs with no gaps at all
  function automatic int unsigned draw_gap(inout int unsigned burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) begin
      burst = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  // Driver: predicts on each input transfer, then loads the next byte after its gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        tokenize(in_item);
        items_left--;
        src_gap = draw_gap(src_burst);
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0 || src_q.size() == 0) begin
          in_valid <= 1'b0;
          if (src_gap > 0) src_gap--;
        end else begin
          in_item  <= src_q.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: checks each output transfer, then stalls for a drawn number of cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_token(out_item);
        snk_gap = draw_gap(snk_burst);
      end
      if (snk_gap > 0) begin
        out_ready <= 1'b0;
        snk_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus builders
  task automatic put_byte(input logic [7:0] c);
    in_item_t it;
    it.character    = c;
    it.end_of_input = 1'b0;
    src_q.push_back(it);
  endtask

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic put_eoi();
    in_item_t it;
    it.character    = 8'($urandom_range(0, 255));
    it.end_of_input = 1'b1;
    src_q.push_back(it);
  endtask

  function automatic logic [7:0] rand_word_byte(input logic lead);
    int r;
    r = int'($urandom_range(0, lead ? 52 : 62));
    if (r < 26) return CH_LC_A + 8'(r);
    if (r < 52) return CH_UC_A + 8'(r - 26);
    if (r == 52) return CH_UNDER;
    return CH_0 + 8'(r - 53);
  endfunction

  function automatic string op_text(input int i);
    case (i)
      0:       return "+";
      1:       return "-";
      2:       return "*";
      3:       return "/";
      4:       return "%";
      5:       return "=";
      6:       return "==";
      7:       return "!=";
      8:       return "<";
      9:       return "<=";
      10:      return ">";
      11:      return ">=";
      12:      return "&&";
      13:      return "||";
      14:      return "!";
      15:      return "(";
      16:      return ")";
      17:      return "{";
      18:      return "}";
      19:      return ";";
      20:      return ",";
      21:      return "&";
      default: return "|";
    endcase
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0:       return CH_TAB;
      1:       return CH_CR;
      2:       return CH_NL;
      default: return CH_SPACE;
    endcase
  endfunction

  // String or char literal with escapes, raw newlines and the odd unclosed one
  task automatic put_literal(input logic [7:0] quote);
    int n;
    put_byte(quote);
    n = int'($urandom_range(0, (quote == CH_SQUOTE) ? 2 : 8));
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: begin
          put_byte(CH_BACKSLASH);
          put_byte(8'($urandom_range(0, 255)));
        end
        1:       put_byte(8'($urandom_range(0, 255)));
        2:       put_byte(CH_NL);
        default: put_byte(8'($urandom_range(32, 126)));
      endcase
    end
    if ($urandom_range(0, 9) != 0) put_byte(quote);
  endtask

  task automatic put_fragment();
    string s;
    int    n;
    case ($urandom_range(0, 19))
      // keyword, sometimes clipped or run on into an identifier
      0, 1, 2: begin
        s = keyword_text(int'($urandom_range(0, 8)));
        if ($urandom_range(0, 7) == 0) s = s.substr(0, s.len() - 2);
        put_text(s);
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 3)) put_byte(rand_word_byte(1'b0));
      end
      3, 4, 5: begin
        n = ($urandom_range(0, 3) == 0) ? int'($urandom_range(7, 10))
                                        : int'($urandom_range(1, 6));
        put_byte(rand_word_byte(1'b1));
        repeat (n - 1) put_byte(rand_word_byte(1'b0));
      end
      6, 7: begin
        put_byte(CH_0 + 8'($urandom_range(0, 9)));
        repeat ($urandom_range(0, 5))
          put_byte(($urandom_range(0, 4) == 0) ? CH_DOT : CH_0 + 8'($urandom_range(0, 9)));
      end
      8, 9:             put_literal(CH_DQUOTE);
      10:               put_literal(CH_SQUOTE);
      11, 12, 13, 14:   put_text(op_text(int'($urandom_range(0, 22))));
      15, 16, 17:       put_byte(blank_byte());
      default:          put_byte(8'($urandom_range(0, 255)));
    endcase
    if ($urandom_range(0, 1) == 0) put_byte(blank_byte());
  endtask

  initial begin
    int base;

    // Directed: keyword, pair operator, float, extreme bytes, lone & and |,
    // escaped newline in a char literal, raw newline in a string
    put_text("if(a>=9.5)");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("&|'\\");
    put_byte(CH_NL);
    put_text("'\"a");
    put_byte(CH_NL);
    put_text("\"<");
    put_eoi();
    // string cut by end of input right after a backslash
    put_text("\"b\\");
    put_eoi();

    // pair operator, then a number flushed by end of input
    put_text("a==b");
    put_byte(CH_NL);
    put_text("; 9");
    put_eoi();

    // Random token streams with some noise
    base = src_q.size();
    while (src_q.size() - base < RAND_ITEMS) begin
      put_fragment();
      if ($urandom_range(0, 79) == 0) put_eoi();
    end
    put_eoi();
    items_left = src_q.size();

    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (items_left != 0 || exp_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0 && exp_tokens.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      if (exp_tokens.size() != 0)
        $display("%0t: %0d expected tokens never arrived", $time, exp_tokens.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/clx_pkg.sv
hw/rtl/clx_step.sv
hw/rtl/clx_res_fifo.sv
hw/rtl/c_subset_lexer.sv
tb/tb.sv
